[hw/rtl/stepper_seek_ramp_controller_unit_macros.svh]
// assertion macros for the stepper seek ramp controller
`ifndef STEPPER_SEEK_RAMP_CONTROLLER_UNIT_MACROS_SVH
`define STEPPER_SEEK_RAMP_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SSRC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SSRC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ssrc_pkg.sv]
// shared constants, types and the coil pattern table of the stepper seek ramp controller
`default_nettype none

package ssrc_pkg;

    // position counter width and ramp length
    localparam int POS_BITS   = 16;
    localparam int RAMP_STEPS = 20;

    // field and register widths
    localparam int SPR_W   = 16;
    localparam int PER_W   = 24;
    localparam int MODE_W  = 3;
    localparam int VAL_W   = 17;
    localparam int COIL_W  = 4;
    localparam int OPOS_W  = 16;
    localparam int WAIT_W  = 28;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 1;

    // derived widths
    localparam int SW      = POS_BITS + 1;
    localparam int CW      = (SW > VAL_W) ? SW : VAL_W;
    localparam int IDX_W   = $clog2(RAMP_STEPS);
    localparam int COEF    = 10 * RAMP_STEPS;
    localparam int COEF_W  = $clog2(COEF + 1);
    localparam int PROD_W  = PER_W + COEF_W;
    localparam int DIV_DW  = VAL_W;
    localparam int DIV_VW  = CW;

    // reciprocal of the ramp length, exact floor division of any ramp product
    localparam int RECIP_SH = PROD_W + $clog2(RAMP_STEPS);
    localparam int RECIP_W  = PROD_W + 1;
    localparam int QP_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(RAMP_STEPS - 1)) / 64'(RAMP_STEPS));

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD   = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 3'd0,
        MODE_SEEK   = 3'd1,
        MODE_ROTATE = 3'd2,
        MODE_ZERO   = 3'd3,
        MODE_POWER  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        RAMP_NONE  = 2'd0,
        RAMP_ACCEL = 2'd1,
        RAMP_DECEL = 2'd2
    } ramp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP,
        ST_MUL,
        ST_SPD,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } st_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_VW-1:0] remainder;
    } div_rsp_t;

    // half-step coil pattern, bit0 drives the first coil
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [2:0] ph);
        logic [COIL_W-1:0] c;
        unique case (ph)
            3'd0: c = 4'h1;
            3'd1: c = 4'h9;
            3'd2: c = 4'h8;
            3'd3: c = 4'hC;
            3'd4: c = 4'h4;
            3'd5: c = 4'h6;
            3'd6: c = 4'h2;
            3'd7: c = 4'h3;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ssrc_cmd_if.sv]
// command channel: mode, value and power flag with valid/ready
`default_nettype none

interface ssrc_cmd_if
    import ssrc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    logic                    power_on;

    modport source (output valid, output mode, output value, output power_on, input ready);
    modport sink   (input valid, input mode, input value, input power_on, output ready);
endinterface

`default_nettype wire

[hw/rtl/ssrc_res_if.sv]
// result channel: coil drive, position, step flag, wait and arrival flag with valid/ready
`default_nettype none

interface ssrc_res_if
    import ssrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COIL_W-1:0] coils;
    logic [OPOS_W-1:0] position;
    logic              stepped;
    logic [WAIT_W-1:0] wait_us;
    logic              ready_res;

    modport source (output valid, output coils, output position, output stepped,
                    output wait_us, output ready_res, input ready);
    modport sink   (input valid, input coils, input position, input stepped,
                    input wait_us, input ready_res, output ready);
endinterface

`default_nettype wire

[hw/rtl/ssrc_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module ssrc_div
    import ssrc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_DW + 1);

    logic [DIV_VW-1:0] rem_reg, rem_next;
    logic [DIV_VW-1:0] dvs_reg, dvs_next;
    logic [DIV_DW-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_VW:0]   trial;
    logic              fits;

    // trial subtraction of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[DIV_DW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_DW);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_VW'(trial - {1'b0, dvs_reg}) : trial[DIV_VW-1:0];
            quo_next = {quo_reg[DIV_DW-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/stepper_seek_ramp_controller_unit.sv]
// top level of the half-step stepper controller with seek, rotate and a linear speed ramp
`default_nettype none
`include "stepper_seek_ramp_controller_unit_macros.svh"

// One command is taken at a time and gives exactly one result. A rotate
// waits in ST_DIV while the bit-serial divider reduces the 17-bit goal
// modulo the steps per revolution, one quotient bit per cycle, and ST_FIX
// then turns the truncating remainder into the goal. A tick that lands inside
// the acceleration or deceleration ramp passes ST_STEP, ST_MUL (a multiply for
// the ramp weight) and ST_SPD (a multiply by the reciprocal of the ramp length),
// a tick at full speed passes ST_STEP only, and a tick with no distance left,
// seek, zero, power and the spare codes go from ST_EXEC to ST_DONE. The
// sequencer then returns to ST_IDLE before the next transfer, and a result
// still held in the output register delays the next result until it has been
// taken. The command channel is ready again as soon as the sequencer is idle,
// even while the previous result still waits in the output register. The configuration port writes
// steps_per_rev (index 0) and base_period_us (index 1) and must only be used while no command is in flight.
module stepper_seek_ramp_controller_unit
    import ssrc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ssrc_cmd_if.sink                  cmd,
    ssrc_res_if.source                res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // sequencer and latched command
    st_t                     state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    power_reg, power_next;

    // configuration
    logic [SPR_W-1:0] spr_reg;
    logic [PER_W-1:0] per_reg;

    // motor state
    logic [2:0]          phase_reg, phase_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] seek_reg, seek_next;
    logic                rot_act_reg, rot_act_next;
    logic [POS_BITS-1:0] goal_reg, goal_next;
    logic [POS_BITS-1:0] origin_reg, origin_next;
    ramp_t               ramp_reg, ramp_next;
    logic                coils_off_reg, coils_off_next;

    // working registers
    logic                dir_up_reg, dir_up_next;
    logic [POS_BITS-1:0] mag_reg, mag_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                stepped_reg, stepped_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;

    // result register
    logic              res_valid_reg, res_valid_next;
    logic [COIL_W-1:0] res_coils_reg, res_coils_next;
    logic [OPOS_W-1:0] res_pos_reg, res_pos_next;
    logic              res_stepped_reg, res_stepped_next;
    logic [WAIT_W-1:0] res_wait_reg, res_wait_next;
    logic              res_rdy_reg, res_rdy_next;

    // combinational helpers
    logic [CW-1:0]          spr_ext, s_lim, s_full;
    logic [SW-1:0]          s_eff;
    logic [POS_BITS-1:0]    s_m1, half;
    logic [VAL_W-1:0]       val_abs;
    logic [POS_BITS-1:0]    clip_val;
    logic [POS_BITS-1:0]    tgt;
    logic signed [SW-1:0]   diff;
    logic [POS_BITS-1:0]    dmag;
    logic                   dnz, dir_up;
    logic [SW-1:0]          pos_inc;
    logic [POS_BITS-1:0]    up_pos, dn_pos, new_pos;
    logic signed [SW-1:0]   org_diff;
    logic [POS_BITS-1:0]    org_mag;
    logic                   mag_small, org_small;
    logic [COEF_W-1:0]      coef;
    logic [QP_W-1:0]        recip_prod;
    logic [SW-1:0]          rot_rem, rot_t;
    logic                   load_res;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    // effective revolution length, clamped to [2, 2^POS_BITS]
    assign spr_ext = CW'(spr_reg);
    assign s_lim   = CW'(1) << POS_BITS;
    assign s_full  = (spr_ext < CW'(2)) ? CW'(2) : ((spr_ext > s_lim) ? s_lim : spr_ext);
    assign s_eff   = s_full[SW-1:0];
    assign s_m1    = POS_BITS'(s_eff - SW'(1));
    assign half    = s_eff[SW-1:1];

    // command value: magnitude and clip to the valid positions
    assign val_abs  = value_reg[VAL_W-1] ? VAL_W'($unsigned(-value_reg))
                                         : VAL_W'($unsigned(value_reg));
    assign clip_val = value_reg[VAL_W-1] ? '0
                    : ((CW'($unsigned(value_reg)) >= CW'(s_eff)) ? s_m1
                       : POS_BITS'($unsigned(value_reg)));

    // remaining distance and direction, rotate takes the shorter way
    assign tgt    = rot_act_reg ? goal_reg : seek_reg;
    assign diff   = $signed({1'b0, tgt}) - $signed({1'b0, pos_reg});
    assign dmag   = diff[SW-1] ? POS_BITS'(-diff) : POS_BITS'(diff);
    assign dnz    = (tgt != pos_reg);
    assign dir_up = rot_act_reg ? (diff[SW-1] ? (dmag > half) : (dmag < half))
                                : !diff[SW-1];

    // one step with wrap, stale positions fold back into range
    assign pos_inc = {1'b0, pos_reg} + SW'(1);
    assign up_pos  = (pos_inc >= s_eff) ? '0 : pos_inc[POS_BITS-1:0];
    assign dn_pos  = ((pos_reg == '0) || ({1'b0, pos_reg} >= s_eff)) ? s_m1
                                                                       : pos_reg - POS_BITS'(1);
    assign new_pos = dir_up_reg ? up_pos : dn_pos;

    // distance from the ramp origin after the step
    assign org_diff  = $signed({1'b0, origin_reg}) - $signed({1'b0, new_pos});
    assign org_mag   = org_diff[SW-1] ? POS_BITS'(-org_diff) : POS_BITS'(org_diff);
    assign mag_small = 33'(mag_reg) < 33'(RAMP_STEPS);
    assign org_small = 33'(org_mag) < 33'(RAMP_STEPS);

    // ramp weight: i*P + (R-i)*10P = P*(10R - 9i)
    assign coef = COEF_W'(COEF) - COEF_W'(idx_reg) * COEF_W'(9);

    // division of the ramp product by the ramp length through its reciprocal
    assign recip_prod = QP_W'(prod_reg) * QP_W'(RECIP);

    // rotate goal from the truncating remainder
    assign rot_rem = div_rsp.remainder[SW-1:0];
    assign rot_t   = (value_reg[VAL_W-1] && (rot_rem != '0)) ? (s_eff - rot_rem) : rot_rem;

    // divider request: goal modulo the revolution length for rotate
    assign div_req.start    = (state_reg == ST_EXEC) && (mode_reg == MODE_ROTATE);
    assign div_req.dividend = DIV_DW'(val_abs);
    assign div_req.divisor  = DIV_VW'(s_eff);

    ssrc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign load_res = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        value_next     = value_reg;
        power_next     = power_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        seek_next      = seek_reg;
        rot_act_next   = rot_act_reg;
        goal_next      = goal_reg;
        origin_next    = origin_reg;
        ramp_next      = ramp_reg;
        coils_off_next = coils_off_reg;
        dir_up_next    = dir_up_reg;
        mag_next       = mag_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        stepped_next   = stepped_reg;
        wait_next      = wait_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next  = mode_t'(cmd.mode);
                    value_next = cmd.value;
                    power_next = cmd.power_on;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                stepped_next = 1'b0;
                wait_next    = '0;
                state_next   = ST_DONE;
                unique case (mode_reg)
                    MODE_TICK:
                    begin
                        dir_up_next = dir_up;
                        mag_next    = dmag;
                        if (dnz)
                        begin
                            state_next = ST_STEP;
                        end
                    end
                    MODE_SEEK:
                    begin
                        seek_next = clip_val;
                        if (rot_act_reg ? (goal_reg != pos_reg) : (clip_val != pos_reg))
                        begin
                            origin_next = pos_reg;
                            ramp_next   = RAMP_ACCEL;
                        end
                    end
                    MODE_ROTATE:
                    begin
                        state_next = ST_DIV;
                    end
                    MODE_ZERO:
                    begin
                        seek_next = clip_val;
                        pos_next  = clip_val;
                    end
                    MODE_POWER:
                    begin
                        coils_off_next = !power_reg;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_STEP:
            begin
                stepped_next   = 1'b1;
                coils_off_next = 1'b0;
                phase_next     = dir_up_reg ? phase_reg + 3'd1 : phase_reg - 3'd1;
                pos_next       = new_pos;
                if (rot_act_reg && (goal_reg == new_pos))
                begin
                    rot_act_next = 1'b0;
                    seek_next    = new_pos;
                end
                // ramp selection: deceleration first, then acceleration, else full speed
                priority if (mag_small)
                begin
                    ramp_next  = RAMP_DECEL;
                    idx_next   = IDX_W'(mag_reg);
                    state_next = ST_MUL;
                end
                else if ((ramp_reg == RAMP_ACCEL) && org_small)
                begin
                    idx_next   = IDX_W'(org_mag);
                    state_next = ST_MUL;
                end
                else
                begin
                    ramp_next  = RAMP_NONE;
                    wait_next  = WAIT_W'(per_reg);
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(per_reg) * PROD_W'(coef);
                state_next = ST_SPD;
            end
            ST_SPD:
            begin
                wait_next  = WAIT_W'(recip_prod >> RECIP_SH);
                state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (rot_t != {1'b0, pos_reg})
                begin
                    rot_act_next = 1'b1;
                    goal_next    = POS_BITS'(rot_t);
                    origin_next  = pos_reg;
                    ramp_next    = RAMP_ACCEL;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_res)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register loads at the end of a command and frees on transfer
    always_comb
    begin
        res_valid_next   = res_valid_reg;
        res_coils_next   = res_coils_reg;
        res_pos_next     = res_pos_reg;
        res_stepped_next = res_stepped_reg;
        res_wait_next    = res_wait_reg;
        res_rdy_next     = res_rdy_reg;
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (load_res)
        begin
            res_valid_next   = 1'b1;
            res_coils_next   = coils_off_reg ? '0 : coil_pattern(phase_reg);
            res_pos_next     = OPOS_W'(pos_reg);
            res_stepped_next = stepped_reg;
            res_wait_next    = wait_reg;
            res_rdy_next     = !dnz;
        end
    end

    // control and motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            pos_reg       <= '0;
            seek_reg      <= '0;
            rot_act_reg   <= 1'b0;
            goal_reg      <= '0;
            origin_reg    <= '0;
            ramp_reg      <= RAMP_NONE;
            coils_off_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            seek_reg      <= seek_next;
            rot_act_reg   <= rot_act_next;
            goal_reg      <= goal_next;
            origin_reg    <= origin_next;
            ramp_reg      <= ramp_next;
            coils_off_reg <= coils_off_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= SPR_W'(4096);
            per_reg <= PER_W'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEPS_PER_REV: spr_reg <= cfg_data[SPR_W-1:0];
                REG_BASE_PERIOD:   per_reg <= cfg_data[PER_W-1:0];
                default:           spr_reg <= spr_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        value_reg       <= value_next;
        power_reg       <= power_next;
        dir_up_reg      <= dir_up_next;
        mag_reg         <= mag_next;
        idx_reg         <= idx_next;
        prod_reg        <= prod_next;
        stepped_reg     <= stepped_next;
        wait_reg        <= wait_next;
        res_coils_reg   <= res_coils_next;
        res_pos_reg     <= res_pos_next;
        res_stepped_reg <= res_stepped_next;
        res_wait_reg    <= res_wait_next;
        res_rdy_reg     <= res_rdy_next;
    end

    // channel outputs
    assign cmd.ready     = (state_reg == ST_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.coils     = res_coils_reg;
    assign res.position  = res_pos_reg;
    assign res.stepped   = res_stepped_reg;
    assign res.wait_us   = res_wait_reg;
    assign res.ready_res = res_rdy_reg;

    // checks
    `SSRC_ASSERT_NEXT(a_cmd_starts, cmd.valid && cmd.ready, state_reg == ST_EXEC, "transfer did not start the sequencer")
    `SSRC_ASSERT_SAME(a_div_done_expected, div_rsp.done, state_reg == ST_DIV, "divider finished outside its wait state")
    `SSRC_ASSERT_NEXT(a_result_loaded, load_res, res_valid_reg, "finished command left no result")
    `SSRC_ASSERT_SAME(a_step_drives_coils, res_valid_reg && res_stepped_reg, res_coils_reg != '0, "step reported with coils off")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the half-step stepper controller with seek, rotate and ramp
`default_nettype none

module tb_top;
    import ssrc_pkg::*;

    // spare command codes that the block must answer without changing state
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PHASE_ITEMS  = 280;
    localparam int SETTLE_TICKS = 150;
    localparam int TAIL_CYCLES  = 50;

    // predictor of the controller plus the queue of expected status words
    class stepper_scoreboard;
        typedef struct packed {
            logic [COIL_W-1:0] coils;
            logic [OPOS_W-1:0] position;
            logic              stepped;
            logic [WAIT_W-1:0] wait_us;
            logic              arrived;
        } status_t;

        status_t          status_q[$];
        logic [SPR_W-1:0] spr;
        logic [PER_W-1:0] period;
        logic [2:0]       ph;
        longint           pos;
        longint           target;
        longint           goal;
        longint           origin;
        bit               rot_on;
        ramp_t            ramp;
        bit               coils_off;
        int               errors;
        int               results;
        int               step_count;

        function new();
            spr        = 16'd4096;
            period     = 24'd1000;
            ph         = 3'd0;
            pos        = 0;
            target     = 0;
            goal       = 0;
            origin     = 0;
            rot_on     = 1'b0;
            ramp       = RAMP_NONE;
            coils_off  = 1'b0;
            errors     = 0;
            results    = 0;
            step_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_STEPS_PER_REV)
                spr = data[SPR_W-1:0];
            else
                period = data[PER_W-1:0];
        endfunction

        // effective revolution length, held within 2 .. 2^POS_BITS
        function longint span();
            longint s;
            s = longint'(spr);
            if (s < 2)
                s = 2;
            if (s > (longint'(1) << POS_BITS))
                s = longint'(1) << POS_BITS;
            return s;
        endfunction

        function longint clip(longint t);
            if (t < 0)
                return 0;
            if (t >= span())
                return span() - 1;
            return t;
        endfunction

        function longint mag_of(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // signed distance still to go; a rotate flips its sign from half a turn on
        function longint remaining();
            longint d;
            longint half;
            if (!rot_on)
                return target - pos;
            d = goal - pos;
            if (d == 0)
                return 0;
            half = span() / 2;
            if (d > 0)
                return (d < half) ? d : -d;
            return (d >= -half) ? d : -d;
        endfunction

        function bit settled();
            return remaining() == 0;
        endfunction

        function longint cur_pos();
            return pos;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // linear profile from ten times down to one times the base period
        function longint ramp_wait(longint i);
            longint p;
            p = longint'(period);
            return (i * p + (RAMP_STEPS - i) * 10 * p) / RAMP_STEPS;
        endfunction

        function logic [COIL_W-1:0] coil_drive(logic [2:0] p);
            case (p)
                3'd0:    return 4'h1;
                3'd1:    return 4'h9;
                3'd2:    return 4'h8;
                3'd3:    return 4'hC;
                3'd4:    return 4'h4;
                3'd5:    return 4'h6;
                3'd6:    return 4'h2;
                default: return 4'h3;
            endcase
        endfunction

        function void begin_ramp();
            if (remaining() != 0)
            begin
                origin = pos;
                ramp   = RAMP_ACCEL;
            end
        endfunction

        // apply one accepted command and queue the status it must produce
        function void note_cmd(logic [MODE_W-1:0] mode, int value, logic pwr);
            longint  s;
            longint  togo;
            longint  mv;
            longint  from_origin;
            longint  t;
            longint  w;
            bit      moved;
            status_t st;
            s     = span();
            w     = 0;
            moved = 1'b0;
            case (mode)
                MODE_TICK:
                begin
                    togo = remaining();
                    if (togo != 0)
                    begin
                        moved     = 1'b1;
                        coils_off = 1'b0;
                        if (togo > 0)
                        begin
                            ph  = ph + 3'd1;
                            pos = (pos + 1 >= s) ? 0 : pos + 1;
                        end
                        else
                        begin
                            ph  = ph - 3'd1;
                            pos = (pos == 0 || pos >= s) ? s - 1 : pos - 1;
                        end
                        if (rot_on && goal == pos)
                        begin
                            rot_on = 1'b0;
                            target = pos;
                        end
                        mv          = mag_of(togo);
                        from_origin = mag_of(origin - pos);
                        if (mv < RAMP_STEPS)
                        begin
                            ramp = RAMP_DECEL;
                            w    = ramp_wait(mv);
                        end
                        else if (ramp == RAMP_ACCEL && from_origin < RAMP_STEPS)
                        begin
                            w = ramp_wait(from_origin);
                        end
                        else
                        begin
                            ramp = RAMP_NONE;
                            w    = longint'(period);
                        end
                    end
                end
                MODE_SEEK:
                begin
                    target = clip(value);
                    begin_ramp();
                end
                MODE_ROTATE:
                begin
                    t = longint'(value) % s;
                    if (t < 0)
                        t = t + s;
                    if (t != pos)
                    begin
                        rot_on = 1'b1;
                        goal   = t;
                        begin_ramp();
                    end
                end
                MODE_ZERO:
                begin
                    t      = clip(value);
                    target = t;
                    pos    = t;
                end
                MODE_POWER:
                    coils_off = !pwr;
                default:
                    ;
            endcase
            if (moved)
                step_count++;
            st.coils    = coils_off ? 4'h0 : coil_drive(ph);
            st.position = pos[OPOS_W-1:0];
            st.stepped  = moved;
            st.wait_us  = w[WAIT_W-1:0];
            st.arrived  = settled();
            status_q.push_back(st);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("mismatch: %s", msg);
        endtask

        // compare one accepted result with the oldest expectation
        task check_res(logic [COIL_W-1:0] coils, logic [OPOS_W-1:0] position,
                       logic stepped, logic [WAIT_W-1:0] wait_us, logic arrived);
            status_t e;
            if (status_q.size() == 0)
            begin
                report("result transfer with no command outstanding");
                return;
            end
            e = status_q.pop_front();
            results++;
            if (coils !== e.coils)
                report($sformatf("result %0d coils %h, want %h", results, coils, e.coils));
            if (position !== e.position)
                report($sformatf("result %0d position %0d, want %0d",
                                 results, position, e.position));
            if (stepped !== e.stepped)
                report($sformatf("result %0d stepped %b, want %b", results, stepped, e.stepped));
            if (wait_us !== e.wait_us)
                report($sformatf("result %0d wait_us %0d, want %0d",
                                 results, wait_us, e.wait_us));
            if (arrived !== e.arrived)
                report($sformatf("result %0d ready_res %b, want %b",
                                 results, arrived, e.arrived));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ssrc_cmd_if cmd_ch();
    ssrc_res_if res_ch();

    stepper_scoreboard sb;
    int src_idle_pct;
    int stall_pct;
    int items;
    int cfg_writes;
    int cycle_cnt = 0;

    stepper_seek_ramp_controller_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= stall_pct);

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_res(res_ch.coils, res_ch.position, res_ch.stepped,
                         res_ch.wait_us, res_ch.ready_res);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int rand_value();
        return int'($urandom_range(0, 131071)) - 65536;
    endfunction

    function automatic int fit17(longint v);
        if (v < -65536)
            return -65536;
        if (v > 65535)
            return 65535;
        return int'(v);
    endfunction

    // one command transfer, with random idle cycles in front
    task automatic send_cmd(logic [MODE_W-1:0] mode, int value, logic pwr);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= mode;
        cmd_ch.value    <= value[VAL_W-1:0];
        cmd_ch.power_on <= pwr;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_cmd(mode, value, pwr);
        items++;
    endtask

    task automatic tick();
        send_cmd(MODE_TICK, rand_value(), 1'($urandom_range(1)));
    endtask

    // hold off until every outstanding status has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    task automatic reconfigure(logic [SPR_W-1:0] spr, logic [PER_W-1:0] per);
        drain();
        if ($urandom_range(1))
        begin
            write_reg(REG_STEPS_PER_REV, CFG_W'(spr));
            write_reg(REG_BASE_PERIOD, per);
        end
        else
        begin
            write_reg(REG_BASE_PERIOD, per);
            write_reg(REG_STEPS_PER_REV, CFG_W'(spr));
        end
    endtask

    // mostly short revolutions, with the extremes now and then
    task automatic reconfigure_random();
        int r;
        int spr;
        int per;
        r = $urandom_range(15);
        case (r)
            0:       spr = 0;
            1:       spr = 1;
            2:       spr = 2;
            3:       spr = 65535;
            4:       spr = 4096;
            5, 6, 7: spr = $urandom_range(200, 3000);
            default: spr = $urandom_range(3, 300);
        endcase
        r = $urandom_range(7);
        case (r)
            0:       per = 1;
            1:       per = 16777215;
            2:       per = $urandom_range(1, 16777215);
            default: per = $urandom_range(1, 5000);
        endcase
        reconfigure(spr[SPR_W-1:0], per[PER_W-1:0]);
    endtask

    // a target near the current position, or at times anywhere when the turn is short
    function automatic int rotate_value(longint off);
        longint s;
        s = sb.span();
        if (s <= 400 && $urandom_range(1))
            return rand_value();
        return fit17(sb.cur_pos() + off - (($urandom_range(3) == 0) ? s : 0));
    endfunction

    // a well-formed move: set a goal, then tick until it is reached or the tick limit runs out
    task automatic run_move();
        longint off;
        longint off2;
        int     kind;
        int     n;
        off  = $urandom_range(0, 48);
        off2 = $urandom_range(0, 48);
        if ($urandom_range(7) == 0)
            off = $urandom_range(0, 90);
        if ($urandom_range(1))
            off = -off;
        if ($urandom_range(1))
            off2 = -off2;
        kind = $urandom_range(99);
        if ($urandom_range(9) == 0)
            send_cmd(MODE_POWER, rand_value(), 1'b0);
        if (kind < 45)
        begin
            send_cmd(MODE_SEEK,
                     ($urandom_range(7) == 0) ? rand_value() : fit17(sb.cur_pos() + off),
                     1'($urandom_range(1)));
        end
        else if (kind < 85)
        begin
            send_cmd(MODE_ROTATE, rotate_value(off), 1'($urandom_range(1)));
        end
        else
        begin
            send_cmd(MODE_ZERO, $urandom_range(1) ? rand_value() : fit17(sb.cur_pos() + off),
                     1'($urandom_range(1)));
            send_cmd(MODE_SEEK, fit17(sb.cur_pos() + off2), 1'($urandom_range(1)));
        end
        n = 0;
        while (!sb.settled() && n < SETTLE_TICKS)
        begin
            tick();
            n++;
        end
        repeat ($urandom_range(0, 2))
            tick();
    endtask

    // a single unrelated command
    task automatic run_noise();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            tick();
        else if (r < 45)
            send_cmd(MODE_SEEK, rand_value(), 1'($urandom_range(1)));
        else if (r < 58)
            send_cmd(MODE_ROTATE, rotate_value(longint'($urandom_range(0, 100)) - 50),
                     1'($urandom_range(1)));
        else if (r < 70)
            send_cmd(MODE_ZERO, rand_value(), 1'($urandom_range(1)));
        else if (r < 85)
            send_cmd(MODE_POWER, rand_value(), 1'($urandom_range(1)));
        else
            send_cmd(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), rand_value(),
                     1'($urandom_range(1)));
    endtask

    // main sequence
    initial
    begin
        int src_pct[4];
        int snk_pct[4];
        int phase_start;
        int next_cfg;
        src_pct = '{0, 52, 0, 25};
        snk_pct = '{0, 0, 52, 25};
        sb              = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_STEPS_PER_REV;
        cfg_data        = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_TICK;
        cmd_ch.value    = '0;
        cmd_ch.power_on = 1'b0;
        src_idle_pct    = 0;
        stall_pct       = 0;
        items           = 0;
        cfg_writes      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, power gating, clipping, wrap and the rotate sign rule
        tick();
        send_cmd(MODE_POWER, 0, 1'b0);
        tick();
        send_cmd(MODE_POWER, 0, 1'b1);
        send_cmd(MODE_SEEK, -65536, 1'b0);
        send_cmd(MODE_SEEK, 65535, 1'b1);
        tick();
        tick();
        send_cmd(MODE_ZERO, 65535, 1'b0);
        send_cmd(MODE_ZERO, -65536, 1'b1);
        send_cmd(MODE_ROTATE, -1, 1'b0);
        tick();
        send_cmd(MODE_ZERO, 0, 1'b0);
        send_cmd(MODE_ROTATE, 2048, 1'b1);
        tick();
        tick();
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_cmd(m[MODE_W-1:0], rand_value(), 1'b1);
        send_cmd(MODE_POWER, 0, 1'b0);
        send_cmd(MODE_SEEK, 4000, 1'b0);
        tick();

        // stale position after shrinking the revolution, then the lower clamp
        reconfigure(16'd100, 24'd1);
        send_cmd(MODE_SEEK, 10, 1'b0);
        tick();
        send_cmd(MODE_ROTATE, 250, 1'b0);
        tick();
        reconfigure(16'd1, 24'd16777215);
        send_cmd(MODE_ROTATE, -3, 1'b1);
        tick();

        // random phases with different idle and stall patterns
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = src_pct[p];
            stall_pct    = snk_pct[p];
            phase_start  = items;
            reconfigure_random();
            next_cfg = items + $urandom_range(50, 90);
            while (items - phase_start < PHASE_ITEMS)
            begin
                if (items >= next_cfg)
                begin
                    reconfigure_random();
                    next_cfg = items + $urandom_range(50, 90);
                end
                if ($urandom_range(99) < 78)
                    run_move();
                else
                    run_noise();
            end
        end

        // let everything outstanding come back, then watch for strays
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        $display("ran %0d commands, checked %0d results, %0d of them steps", items,
                 sb.results, sb.step_count);
        $display("%0d register writes across four idle and stall patterns", cfg_writes);
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
